### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/bqsgl_pkg.sv
// ----------------------------------------------------------------------------
// bqsgl_pkg
// Types and constants for the biquad, gain and limiter core.
// ----------------------------------------------------------------------------
package bqsgl_pkg;

  localparam int SMP_W    = 16;  // Q1.15 sample
  localparam int COEF_W   = 20;  // Q3.16 coefficient, also Q4.15 filter state
  localparam int GAIN_W   = 12;  // Q4.8 gain
  localparam int LIM_W    = 15;  // Q1.15 clamp magnitude
  localparam int IDX_W    = 3;   // register index
  localparam int PROD_W   = 2 * COEF_W;
  localparam int ACC_W    = PROD_W + 3;  // sum of five products
  localparam int FILT_SH  = 16;          // Q.31 -> Q.15
  localparam int GAIN_SH  = 8;           // Q.23 -> Q.15

  localparam int FILT_MAX = 524287;
  localparam int FILT_MIN = -524288;

  // Reset values
  localparam logic signed [COEF_W-1:0] COEF_B0_RST  = 20'sd65536;
  localparam logic [GAIN_W-1:0]        GAIN_RST     = 12'd1536;
  localparam logic [LIM_W-1:0]         CLIP_RST     = 15'd31130;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_B0,
    REG_COEF_B1,
    REG_COEF_B2,
    REG_COEF_A1,
    REG_COEF_A2,
    REG_MASTER_GAIN,
    REG_CLIP_LIMIT
  } reg_idx_t;

  // Filter taps in issue order
  typedef enum logic [2:0] {
    TAP_B0,
    TAP_B1,
    TAP_B2,
    TAP_A1,
    TAP_A2
  } tap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_ROUND,
    ST_GAIN,
    ST_OUT
  } state_t;

  // Configuration bundle from the register file
  typedef struct packed {
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic [GAIN_W-1:0]        master_gain;
    logic [LIM_W-1:0]         clip_limit;
  } cfg_t;

endpackage

### hw/rtl/biquad_shelf_gain_limiter_core.sv
// The single shared 20x20 multiplier issues five filter products and one gain
//   product per sample; no sample is taken until the last result is loaded.
// The next sample is taken while a result still waits on the output register.
// Reset (rst_n low, synchronous): registers to defaults, filter history to zero.
// ----------------------------------------------------------------------------
// biquad_shelf_gain_limiter_core
// Direct-form-I biquad, post gain and symmetric clamp, one shared multiplier
// stepped by a small sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_shelf_gain_limiter_core
  import bqsgl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] sample_in
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [15:0] sample_out
  // Configuration write port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata
);

  localparam int SHR_W  = ACC_W + 1 - FILT_SH;   // rounded filter sum
  localparam int GSHR_W = PROD_W + 1 - GAIN_SH;  // rounded gain product

  cfg_t cfg;

  state_t state_r, state_nxt;
  tap_t   tap_r, tap_nxt;

  logic                     mul_en;
  logic signed [COEF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_sub_r;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  addend;
  logic signed [SMP_W-1:0]  x_r, pin1_r, pin2_r;
  logic signed [COEF_W-1:0] pf1_r, pf2_r;

  logic signed [ACC_W:0]    acc_rnd;
  logic signed [SHR_W-1:0]  acc_shr;
  logic signed [COEF_W-1:0] y_sat;

  logic signed [PROD_W:0]   g_rnd;
  logic signed [GSHR_W-1:0] g_shr;
  logic signed [SMP_W-1:0]  lim_s;
  logic signed [SMP_W-1:0]  g_clamp;

  logic                     out_valid_r;
  logic [SMP_W-1:0]         out_data_r;
  logic                     in_xfer, out_load;
  logic signed [SMP_W-1:0]  out_s;

  bqsgl_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bqsgl_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = cfg.coef_b0;
    mul_b = COEF_W'(x_r);
    if (state_r == ST_GAIN) begin
      mul_a = pf1_r;
      mul_b = $signed({{(COEF_W-GAIN_W){1'b0}}, cfg.master_gain});
    end else begin
      unique case (tap_r)
        TAP_B0: begin mul_a = cfg.coef_b0; mul_b = COEF_W'(x_r);    end
        TAP_B1: begin mul_a = cfg.coef_b1; mul_b = COEF_W'(pin1_r); end
        TAP_B2: begin mul_a = cfg.coef_b2; mul_b = COEF_W'(pin2_r); end
        TAP_A1: begin mul_a = cfg.coef_a1; mul_b = pf1_r;           end
        TAP_A2: begin mul_a = cfg.coef_a2; mul_b = pf2_r;           end
        default: begin end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    mul_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        tap_nxt = TAP_B0;
        if (in_xfer) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        mul_en = 1'b1;
        if (tap_r == TAP_A2) begin
          state_nxt = ST_FLUSH;
        end else begin
          tap_nxt = tap_t'(tap_r + 3'd1);
        end
      end
      ST_FLUSH: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_GAIN;
      ST_GAIN: begin
        mul_en    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= TAP_B0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  // Feedback taps enter the sum negated
  assign addend = prod_sub_r ? -ACC_W'(prod) : ACC_W'(prod);

  // Filter rounding, half up, then saturation to Q4.15
  assign acc_rnd = ACC_W'(acc_r) + (ACC_W+1)'(1 << (FILT_SH - 1));
  assign acc_shr = $signed(acc_rnd[ACC_W:FILT_SH]);
  always_comb begin
    if (acc_shr > SHR_W'(FILT_MAX)) begin
      y_sat = COEF_W'(FILT_MAX);
    end else if (acc_shr < SHR_W'(FILT_MIN)) begin
      y_sat = COEF_W'(FILT_MIN);
    end else begin
      y_sat = acc_shr[COEF_W-1:0];
    end
  end

  // Gain rounding and symmetric clamp
  assign lim_s   = $signed({1'b0, cfg.clip_limit});
  assign g_rnd   = PROD_W'(prod) + (PROD_W+1)'(1 << (GAIN_SH - 1));
  assign g_shr   = $signed(g_rnd[PROD_W:GAIN_SH]);
  always_comb begin
    if (g_shr > GSHR_W'(lim_s)) begin
      g_clamp = lim_s;
    end else if (g_shr < -GSHR_W'(lim_s)) begin
      g_clamp = -lim_s;
    end else begin
      g_clamp = g_shr[SMP_W-1:0];
    end
  end

  // Accumulator and sample capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r   <= $signed(in_tdata);
      acc_r <= '0;
    end
    if (state_r == ST_MAC) begin
      prod_sub_r <= (tap_r == TAP_A1) || (tap_r == TAP_A2);
      if (tap_r != TAP_B0) begin
        acc_r <= acc_r + addend;
      end
    end
    if (state_r == ST_FLUSH) begin
      acc_r <= acc_r + addend;
    end
  end

  // Filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin1_r <= '0;
      pin2_r <= '0;
      pf1_r  <= '0;
      pf2_r  <= '0;
    end else if (state_r == ST_ROUND) begin
      pin2_r <= pin1_r;
      pin1_r <= x_r;
      pf2_r  <= pf1_r;
      pf1_r  <= y_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= g_clamp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_s      = $signed(out_data_r);

  // Checks
  `ASSERT_NXT(a_accept_starts_mac, in_xfer, (state_r == ST_MAC) && (tap_r == TAP_B0))
  `ASSERT_IMP(a_out_within_limit, out_tvalid, (out_s <= lim_s) && (out_s >= -lim_s))
  `ASSERT_NXT(a_out_wait_holds, (state_r == ST_OUT) && out_tvalid && !out_tready, state_r == ST_OUT)
  `ASSERT_NXT(a_out_load_idle, out_load, out_tvalid && (state_r == ST_IDLE))

endmodule

### hw/rtl/bqsgl_regs.sv
// ----------------------------------------------------------------------------
// bqsgl_regs
// Configuration register file: coefficients, gain and clamp limit.
// ----------------------------------------------------------------------------
module bqsgl_regs
  import bqsgl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;

  // Write decode; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_b0     <= COEF_B0_RST;
      cfg_r.coef_b1     <= '0;
      cfg_r.coef_b2     <= '0;
      cfg_r.coef_a1     <= '0;
      cfg_r.coef_a2     <= '0;
      cfg_r.master_gain <= GAIN_RST;
      cfg_r.clip_limit  <= CLIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_B0:     cfg_r.coef_b0     <= $signed(cfg_wdata);
        REG_COEF_B1:     cfg_r.coef_b1     <= $signed(cfg_wdata);
        REG_COEF_B2:     cfg_r.coef_b2     <= $signed(cfg_wdata);
        REG_COEF_A1:     cfg_r.coef_a1     <= $signed(cfg_wdata);
        REG_COEF_A2:     cfg_r.coef_a2     <= $signed(cfg_wdata);
        REG_MASTER_GAIN: cfg_r.master_gain <= cfg_wdata[GAIN_W-1:0];
        REG_CLIP_LIMIT:  cfg_r.clip_limit  <= cfg_wdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/bqsgl_mul.sv
// ----------------------------------------------------------------------------
// bqsgl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module bqsgl_mul
  import bqsgl_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COEF_W-1:0] op_a,
  input  logic signed [COEF_W-1:0] op_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  // Product register, loaded only when a product is issued
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

### dv/biquad_shelf_gain_limiter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_shelf_gain_limiter_core_tb
// Streams Q1.15 samples through the biquad, gain and clamp core and checks
// every output transfer against a table value or an in-bench fixed-point
// predictor. A short directed table covers the reset setup, field extremes,
// a zero clamp, filter saturation and an undecoded register write. Random
// phases with fresh register settings follow. Both stream sides idle in
// random bursts; one long output hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module biquad_shelf_gain_limiter_core_tb;
  import bqsgl_pkg::*;

  // Index with no register behind it
  localparam logic [IDX_W-1:0]  REG_SPARE = 3'd7;
  localparam logic [COEF_W-1:0] COEF_MIN  = 20'h80000;
  localparam logic [COEF_W-1:0] COEF_MAX  = 20'h7FFFF;
  localparam logic [COEF_W-1:0] COEF_ONE  = 20'h10000;
  localparam logic [COEF_W-1:0] CLIP_FULL = 20'h07FFF;

  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 103;
  localparam int DRAIN_CYCLES = 12;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int TIMEOUT_NS   = 5_000_000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // [15:0] sample_in
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // [15:0] sample_out
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  biquad_shelf_gain_limiter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow registers and filter history, reset values
  logic signed [COEF_W-1:0] sh_b0 = COEF_B0_RST;
  logic signed [COEF_W-1:0] sh_b1 = '0;
  logic signed [COEF_W-1:0] sh_b2 = '0;
  logic signed [COEF_W-1:0] sh_a1 = '0;
  logic signed [COEF_W-1:0] sh_a2 = '0;
  logic [GAIN_W-1:0]        sh_gain = GAIN_RST;
  logic [LIM_W-1:0]         sh_clip = CLIP_RST;
  logic signed [SMP_W-1:0]  hist_x1 = '0;
  logic signed [SMP_W-1:0]  hist_x2 = '0;
  logic signed [COEF_W-1:0] hist_y1 = '0;
  logic signed [COEF_W-1:0] hist_y2 = '0;

  logic [SMP_W-1:0] pending_out_samples[$];
  int               mismatch_count = 0;
  bit               gaps_on = 1'b1;
  bit               hold_req = 1'b0;

  // Directed stimulus table
  typedef struct {
    bit                is_reg;
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] wdata;
    logic [SMP_W-1:0]  smp;
    bit                known;
    logic [SMP_W-1:0]  want;
  } directed_row_t;

  directed_row_t plan[$];

  function automatic void add_write(input logic [IDX_W-1:0] idx,
                                    input logic [COEF_W-1:0] d);
    directed_row_t r;
    r = '{1'b1, idx, d, '0, 1'b0, '0};
    plan.push_back(r);
  endfunction

  function automatic void add_sample(input logic [SMP_W-1:0] s);
    directed_row_t r;
    r = '{1'b0, '0, '0, s, 1'b0, '0};
    plan.push_back(r);
  endfunction

  function automatic void add_known(input logic [SMP_W-1:0] s,
                                    input logic [SMP_W-1:0] e);
    directed_row_t r;
    r = '{1'b0, '0, '0, s, 1'b1, e};
    plan.push_back(r);
  endfunction

  // Register write as the core decodes it; unknown index is dropped
  function automatic void shadow_write(input logic [IDX_W-1:0] idx,
                                       input logic [COEF_W-1:0] d);
    case (idx)
      REG_COEF_B0:     sh_b0 = d;
      REG_COEF_B1:     sh_b1 = d;
      REG_COEF_B2:     sh_b2 = d;
      REG_COEF_A1:     sh_a1 = d;
      REG_COEF_A2:     sh_a2 = d;
      REG_MASTER_GAIN: sh_gain = d[GAIN_W-1:0];
      REG_CLIP_LIMIT:  sh_clip = d[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // DF1 biquad, Q4.15 saturation, Q4.8 gain, symmetric clamp
  function automatic logic [SMP_W-1:0] biquad_predict(input logic signed [SMP_W-1:0] x);
    longint acc;
    longint y;
    longint g;
    longint lim;
    acc = longint'(sh_b0) * longint'(x)
        + longint'(sh_b1) * longint'(hist_x1)
        + longint'(sh_b2) * longint'(hist_x2)
        - longint'(sh_a1) * longint'(hist_y1)
        - longint'(sh_a2) * longint'(hist_y2);
    // round half up: add half an LSB, arithmetic shift floors
    y = (acc + (longint'(1) << (FILT_SH - 1))) >>> FILT_SH;
    if (y > FILT_MAX) y = FILT_MAX;
    if (y < FILT_MIN) y = FILT_MIN;
    hist_x2 = hist_x1;
    hist_x1 = x;
    hist_y2 = hist_y1;
    hist_y1 = y[COEF_W-1:0];
    g = (y * longint'(sh_gain) + (longint'(1) << (GAIN_SH - 1))) >>> GAIN_SH;
    lim = longint'(sh_clip);
    if (g > lim) g = lim;
    if (g < -lim) g = -lim;
    return g[SMP_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_output(input logic [SMP_W-1:0] got);
    logic [SMP_W-1:0] want;
    if (pending_out_samples.size() == 0) begin
      report_mismatch($sformatf("unexpected sample_out %0d", $signed(got)));
    end else begin
      want = pending_out_samples.pop_front();
      if (got !== want)
        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                  $signed(got), $signed(want)));
    end
  endtask

  // Register write; the caller drops cfg_we after the last one
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    shadow_write(idx, d);
  endtask

  // One input transfer, with an optional idle burst ahead of it
  task automatic send_sample(input logic [SMP_W-1:0] s, input bit known,
                             input logic [SMP_W-1:0] known_val);
    logic [SMP_W-1:0] pred;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    pred = biquad_predict(s);
    pending_out_samples.push_back(known ? known_val : pred);
  endtask

  // Wait for the core to go quiet before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_out_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_output(out_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left == 0 && stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 7);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("biquad_shelf_gain_limiter_core_tb: FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    bit                streaming;
    int                kind;
    int                mode;
    int                span;
    int                v;
    logic [SMP_W-1:0]  s;
    logic [COEF_W-1:0] wd[7];

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    streaming = 1'b0;

    // Reset setup: unity filter, gain 6, clamp 0.95
    add_known(16'h0000, 16'h0000);
    add_known(16'h7FFF, 16'd31130);
    add_known(16'h8000, -16'sd31130);
    add_known(16'h0001, 16'd6);
    add_known(16'hFFFF, -16'sd6);
    add_known(16'd5000, 16'd30000);
    // undecoded index must leave the setup alone
    add_write(REG_SPARE, 20'hFFFFF);
    add_known(16'd5000, 16'd30000);
    // zero clamp forces silence
    add_write(REG_CLIP_LIMIT, '0);
    add_known(16'h7FFF, 16'h0000);
    add_known(16'h8000, 16'h0000);
    add_known(16'h8000, 16'h0000);
    add_known(16'h8000, 16'h0000);
    // most negative taps on full-scale negative history: filter saturates high
    add_write(REG_COEF_B0, COEF_MIN);
    add_write(REG_COEF_B1, COEF_MIN);
    add_write(REG_COEF_B2, COEF_MIN);
    add_write(REG_MASTER_GAIN, 20'd1);
    add_write(REG_CLIP_LIMIT, CLIP_FULL);
    add_known(16'h8000, 16'd2048);
    add_known(16'h8000, 16'd2048);
    add_known(16'h0000, 16'd2048);
    add_sample(16'h7FFF);
    // extreme feedback, maximum gain
    add_write(REG_COEF_B0, COEF_MAX);
    add_write(REG_COEF_B1, COEF_MAX);
    add_write(REG_COEF_B2, COEF_MAX);
    add_write(REG_COEF_A1, COEF_MIN);
    add_write(REG_COEF_A2, COEF_MAX);
    add_write(REG_MASTER_GAIN, 20'hFFF);
    add_sample(16'h7FFF);
    add_sample(16'h8000);
    add_sample(16'd12345);
    add_sample(16'hFFFF);
    // zero gain
    add_write(REG_MASTER_GAIN, '0);
    add_known(16'h7FFF, 16'h0000);
    add_known(16'h8000, 16'h0000);
    add_write(REG_COEF_A1, COEF_MAX);
    add_write(REG_COEF_A2, COEF_MIN);
    add_write(REG_MASTER_GAIN, 20'd256);
    add_write(REG_CLIP_LIMIT, 20'd16384);
    add_sample(16'd100);
    add_sample(-16'sd100);
    add_sample(16'h7FFF);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (streaming) begin
          drain();
          streaming = 1'b0;
        end
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        cfg_we <= 1'b0;
        send_sample(plan[i].smp, plan[i].known, plan[i].want);
        streaming = 1'b1;
      end
    end

    // Random phases, each with its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      kind = (p == 1) ? 1 : $urandom_range(0, 3);
      for (int r = REG_COEF_B0; r <= REG_COEF_A2; r++) begin
        case (kind)
          0: begin
            // moderate taps, mostly stable
            span = (r == REG_COEF_A1) ? 60000 : (r == REG_COEF_A2) ? 30000 : 40000;
            v = int'($urandom_range(0, 2 * span)) - span;
            wd[r] = v[COEF_W-1:0];
          end
          1: wd[r] = COEF_W'($urandom);
          2: begin
            case ($urandom_range(0, 3))
              0:       wd[r] = COEF_MIN;
              1:       wd[r] = COEF_MAX;
              2:       wd[r] = '0;
              default: wd[r] = COEF_ONE;
            endcase
          end
          default: begin
            // near pass-through with small extra taps
            v = int'($urandom_range(0, 4000)) - 2000;
            wd[r] = (r == REG_COEF_B0) ? COEF_ONE : v[COEF_W-1:0];
          end
        endcase
      end
      case (kind)
        0: begin
          wd[REG_MASTER_GAIN] = COEF_W'($urandom_range(64, 1024));
          wd[REG_CLIP_LIMIT]  = COEF_W'($urandom_range(0, 32767));
        end
        1: begin
          // upper bits beyond the register width are junk on purpose
          wd[REG_MASTER_GAIN] = COEF_W'($urandom);
          wd[REG_CLIP_LIMIT]  = COEF_W'($urandom);
        end
        2: begin
          case ($urandom_range(0, 2))
            0:       wd[REG_MASTER_GAIN] = '0;
            1:       wd[REG_MASTER_GAIN] = 20'hFFF;
            default: wd[REG_MASTER_GAIN] = 20'd256;
          endcase
          case ($urandom_range(0, 2))
            0:       wd[REG_CLIP_LIMIT] = '0;
            1:       wd[REG_CLIP_LIMIT] = CLIP_FULL;
            default: wd[REG_CLIP_LIMIT] = 20'd1;
          endcase
        end
        default: begin
          wd[REG_MASTER_GAIN] = 20'd256;
          wd[REG_CLIP_LIMIT]  = CLIP_FULL;
        end
      endcase
      for (int r = REG_COEF_B0; r <= REG_CLIP_LIMIT; r++) write_reg(IDX_W'(r), wd[r]);
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, COEF_W'($urandom));
      cfg_we <= 1'b0;

      // no idling in the last phase and in every fourth one
      gaps_on = (p != RAND_PHASES - 1) && (p % 4 != 3);
      // long output hold-off while input keeps coming
      if (p == 2) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          s = SMP_W'($urandom);
        end else if (mode < 8) begin
          v = int'($urandom_range(0, 4000)) - 2000;
          s = v[SMP_W-1:0];
        end else begin
          case ($urandom_range(0, 3))
            0:       s = 16'h8000;
            1:       s = 16'h7FFF;
            2:       s = 16'h0000;
            default: s = 16'hFFFF;
          endcase
        end
        send_sample(s, 1'b0, '0);
      end
    end

    // Let the last results out
    in_tvalid <= 1'b0;
    while (pending_out_samples.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("biquad_shelf_gain_limiter_core_tb: PASS");
    else
      $display("biquad_shelf_gain_limiter_core_tb: FAIL");
    $finish;
  end

endmodule
